### hdl/prp_seg_pkg.sv
// Shared types and constants for the PRP list segmenter.
// No dependencies; imported by prp_seg_engine and prp_list_segmenter_unit.
`timescale 1ns / 1ps
`default_nettype none

package prp_seg_pkg;

   // Operation codes of an input transaction.
   localparam logic OP_COMMAND   = 1'b0;
   localparam logic OP_LIST_WORD = 1'b1;

   // Result status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_ADDR = 2'd1;
   localparam logic [1:0] ST_NO_LIST  = 2'd2;

   // Register indexes on the configuration port.
   localparam logic REG_LOW_LIMIT = 1'b0;
   localparam logic REG_MAX_ADDR  = 1'b1;

   // Register reset values.
   localparam logic [63:0] LOW_LIMIT_RESET = 64'h0000_0000_0010_0000;
   localparam logic [63:0] MAX_ADDR_RESET  = 64'h0000_1000_0000_0000;

   // Depth of the result queue and its pointer and count widths.
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = 2;
   localparam int CNT_W      = 3;

   typedef struct packed {
      logic        op;
      logic [63:0] first_pointer;
      logic [63:0] second_pointer;
      logic [31:0] transfer_length;
      logic [63:0] list_word;
   } req_item_type;

   typedef struct packed {
      logic [63:0] page_address;
      logic [11:0] page_offset;
      logic [12:0] segment_length;
      logic [9:0]  segment_number;
      logic [1:0]  status;
      logic        wants_list;
      logic        last;
   } rsp_item_type;

   // What one processed transaction produces: one or two results.
   typedef struct packed {
      logic [1:0]   n_results;
      rsp_item_type rsp0;
      rsp_item_type rsp1;
   } step_out_type;

endpackage

`default_nettype wire

### hdl/prp_seg_engine.sv
// Segmenting engine: walker state plus the single-pass logic for one transaction.
// Depends on prp_seg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prp_seg_engine #(
   parameter int PAGE_SHIFT = 12
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       fire,
   input  prp_seg_pkg::req_item_type item,
   input  wire [63:0]                low_limit,
   input  wire [63:0]                max_addr,
   output prp_seg_pkg::step_out_type step_out
);
   import prp_seg_pkg::*;

   localparam int LW = PAGE_SHIFT - 2;
   localparam int WW = 33 - PAGE_SHIFT;
   localparam logic [PAGE_SHIFT:0]   PAGE_BYTES = {1'b1, {PAGE_SHIFT{1'b0}}};
   localparam logic [63:0]           PAGE_MASK  = (64'd1 << PAGE_SHIFT) - 64'd1;
   localparam logic [LW-1:0]         LIST_CAP   = {1'b1, {(PAGE_SHIFT - 3){1'b0}}};

   // Walker state.
   logic          awaiting_ff, awaiting_in;
   logic [31:0]   bytes_ff, bytes_in;
   logic [LW-1:0] words_ff, words_in;
   logic [9:0]    segs_ff, segs_in;

   // Command path.
   logic [PAGE_SHIFT-1:0] p1_off;
   logic [PAGE_SHIFT:0]   first_len;
   logic                  first_fits;
   logic [31:0]           rest;
   logic                  rest_fits;
   logic [32:0]           words_sum;
   logic [WW-1:0]         words_raw;
   logic [LW-1:0]         words_capped;

   // List word path.
   logic [PAGE_SHIFT-1:0] w_off;
   logic [PAGE_SHIFT:0]   w_room;
   logic [31:0]           seg_len;
   logic [31:0]           bytes_after;
   logic [LW-1:0]         words_after;
   logic                  done;

   // An address is bad if zero, below the low limit, wrapping past the top
   // when a page is added, or above the maximum address.
   function automatic logic addr_ok(input logic [63:0] a, input logic [63:0] lo,
                                    input logic [63:0] hi);
      logic ok;
      ok = (a != 64'd0) && (a >= lo) && !(&a[63:PAGE_SHIFT]) && (a <= hi);
      return ok;
   endfunction

   // Command arithmetic: first segment, remainder and list word count.
   always_comb begin
      p1_off       = item.first_pointer[PAGE_SHIFT-1:0];
      first_len    = PAGE_BYTES - {1'b0, p1_off};
      first_fits   = 32'(first_len) >= item.transfer_length;
      rest         = item.transfer_length - 32'(first_len);
      rest_fits    = rest <= 32'(PAGE_BYTES);
      words_sum    = {1'b0, rest} + 33'(PAGE_MASK);
      words_raw    = words_sum[32:PAGE_SHIFT];
      words_capped = (words_raw > WW'(LIST_CAP)) ? LIST_CAP : words_raw[LW-1:0];
   end

   // List word arithmetic: segment clipped to the bytes still owed.
   always_comb begin
      w_off       = item.list_word[PAGE_SHIFT-1:0];
      w_room      = PAGE_BYTES - {1'b0, w_off};
      seg_len     = (32'(w_room) > bytes_ff) ? bytes_ff : 32'(w_room);
      bytes_after = bytes_ff - seg_len;
      words_after = (words_ff != '0) ? (words_ff - LW'(1)) : words_ff;
      done        = (bytes_after == 32'd0) || (words_after == '0);
   end

   // Results and next state for the transaction in the input register.
   always_comb begin
      step_out    = '0;
      awaiting_in = awaiting_ff;
      bytes_in    = bytes_ff;
      words_in    = words_ff;
      segs_in     = segs_ff;
      step_out.n_results = 2'd1;
      step_out.rsp0.last = 1'b1;
      if (item.op == OP_COMMAND) begin
         awaiting_in = 1'b0;
         bytes_in    = '0;
         words_in    = '0;
         segs_in     = '0;
         if (item.transfer_length == 32'd0) begin
            step_out.rsp0.status = ST_OK;
         end else if (!addr_ok(item.first_pointer, low_limit, max_addr)) begin
            step_out.rsp0.status = ST_BAD_ADDR;
         end else if (first_fits) begin
            step_out.rsp0.page_address   = item.first_pointer & ~PAGE_MASK;
            step_out.rsp0.page_offset    = p1_off[11:0];
            step_out.rsp0.segment_length = item.transfer_length[12:0];
         end else if (!addr_ok(item.second_pointer, low_limit, max_addr)) begin
            step_out.rsp0.status         = ST_BAD_ADDR;
            step_out.rsp0.segment_number = 10'd1;
         end else begin
            step_out.rsp0.page_address   = item.first_pointer & ~PAGE_MASK;
            step_out.rsp0.page_offset    = p1_off[11:0];
            step_out.rsp0.segment_length = first_len[12:0];
            if (rest_fits) begin
               // Two pages: PRP2 is the second data page.
               step_out.n_results           = 2'd2;
               step_out.rsp0.last           = 1'b0;
               step_out.rsp1.page_address   = item.second_pointer & ~PAGE_MASK;
               step_out.rsp1.segment_length = rest[12:0];
               step_out.rsp1.segment_number = 10'd1;
               step_out.rsp1.status         = ST_OK;
               step_out.rsp1.last           = 1'b1;
            end else begin
               // Longer transfer: PRP2 points to a list that follows.
               step_out.rsp0.last       = 1'b0;
               step_out.rsp0.wants_list = 1'b1;
               awaiting_in = 1'b1;
               bytes_in    = rest;
               words_in    = words_capped;
               segs_in     = 10'd1;
            end
         end
      end else if (!awaiting_ff) begin
         step_out.rsp0.status = ST_NO_LIST;
      end else if (!addr_ok(item.list_word, low_limit, max_addr)) begin
         step_out.rsp0.status         = ST_BAD_ADDR;
         step_out.rsp0.segment_number = segs_ff;
         awaiting_in = 1'b0;
         bytes_in    = '0;
         words_in    = '0;
      end else begin
         step_out.rsp0.page_address   = item.list_word & ~PAGE_MASK;
         step_out.rsp0.page_offset    = w_off[11:0];
         step_out.rsp0.segment_length = seg_len[12:0];
         step_out.rsp0.segment_number = segs_ff;
         step_out.rsp0.wants_list     = !done;
         step_out.rsp0.last           = done;
         segs_in = segs_ff + 10'd1;
         if (done) begin
            awaiting_in = 1'b0;
            bytes_in    = '0;
            words_in    = '0;
         end else begin
            bytes_in = bytes_after;
            words_in = words_after;
         end
      end
   end

   // State advances only when the transaction is processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff <= 1'b0;
         bytes_ff    <= '0;
         words_ff    <= '0;
         segs_ff     <= '0;
      end else if (fire) begin
         awaiting_ff <= awaiting_in;
         bytes_ff    <= bytes_in;
         words_ff    <= words_in;
         segs_ff     <= segs_in;
      end
   end

`ifndef SYNTH
   // While a list is awaited, the walker always owes bytes and words.
   a_await_owes: assert property (@(posedge clock) disable iff (reset)
      awaiting_ff |-> (bytes_ff != 32'd0) && (words_ff != '0))
      else $error("awaiting list with nothing owed");

   // Idle walker holds no leftover byte or word counts.
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !awaiting_ff |-> (bytes_ff == 32'd0) && (words_ff == '0))
      else $error("idle walker holds stale counts");

   // A result that asks for list words is never the last one.
   a_wants_not_last: assert property (@(posedge clock) disable iff (reset)
      (fire && step_out.rsp0.wants_list) |-> !step_out.rsp0.last && awaiting_in)
      else $error("list request on a final result");
`endif

endmodule

`default_nettype wire

### hdl/prp_list_segmenter_unit.sv
// Top level of the PRP list segmenter: input register, CSRs and result queue.
// Depends on prp_seg_pkg and prp_seg_engine.
//
//   Channel   Direction  Handshake                      Carries
//   req_*     in         req_valid / req_ready          command or one PRP list word
//   rsp_*     out        rsp_valid / rsp_ready          one page segment or status
//   APB       in/out     psel, penable, pwrite, pready  low_address_limit, max_address
//
// One transaction is accepted per cycle while two queue entries are free; each
// yields one result, except a two-page command, which yields two in turn.
// A result reaches the result port through the input register, then the four-entry
// result queue. The queue alone sets the stall: processing waits while fewer than two
// entries are free, and req_ready drops behind it.
// Synchronous reset clears the walker, the queue and the registers to defaults.
`timescale 1ns / 1ps
`default_nettype none

module prp_list_segmenter_unit #(
   parameter int PAGE_SHIFT = 12
) (
   input  wire         clock,
   input  wire         reset,
   // Input transactions.
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_op,
   input  wire  [63:0] req_first_pointer,
   input  wire  [63:0] req_second_pointer,
   input  wire  [31:0] req_transfer_length,
   input  wire  [63:0] req_list_word,
   // Result transactions.
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [63:0] rsp_page_address,
   output logic [11:0] rsp_page_offset,
   output logic [12:0] rsp_segment_length,
   output logic [9:0]  rsp_segment_number,
   output logic [1:0]  rsp_status,
   output logic        rsp_wants_list,
   output logic        rsp_last,
   // Configuration port.
   input  wire         psel,
   input  wire         penable,
   input  wire         pwrite,
   input  wire  [3:0]  paddr,
   input  wire  [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);
   import prp_seg_pkg::*;

   // Configuration registers.
   logic [63:0] low_limit_ff, max_addr_ff;
   logic        csr_write;

   // Input register.
   logic         in_valid_ff;
   req_item_type in_item_ff;
   req_item_type req_item;
   logic         fire;

   // Result queue.
   rsp_item_type           fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [1:0]             push_n;
   logic                   pop;
   step_out_type           step_out;
   rsp_item_type           head;

   // APB: always ready; register index sits in address bit 3.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign prdata    = (paddr[3] == REG_MAX_ADDR) ? max_addr_ff : low_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_limit_ff <= LOW_LIMIT_RESET;
         max_addr_ff  <= MAX_ADDR_RESET;
      end else if (csr_write) begin
         if (paddr[3] == REG_LOW_LIMIT) begin
            low_limit_ff <= pwdata;
         end else begin
            max_addr_ff <= pwdata;
         end
      end
   end

   // Input register: refilled whenever it is empty or its transaction moves on.
   assign fire      = in_valid_ff && (count_ff <= CNT_W'(FIFO_DEPTH - 2));
   assign req_ready = !in_valid_ff || fire;

   always_comb begin
      req_item.op              = req_op;
      req_item.first_pointer   = req_first_pointer;
      req_item.second_pointer  = req_second_pointer;
      req_item.transfer_length = req_transfer_length;
      req_item.list_word       = req_list_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_item_ff <= req_item;
      end
   end

   prp_seg_engine #(
      .PAGE_SHIFT(PAGE_SHIFT)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .item     (in_item_ff),
      .low_limit(low_limit_ff),
      .max_addr (max_addr_ff),
      .step_out (step_out)
   );

   // Result queue: up to two pushes and one pop per cycle.
   assign push_n    = fire ? step_out.n_results : 2'd0;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PTR_W'(push_n);
         rd_ptr_ff <= rd_ptr_ff + PTR_W'(pop);
         count_ff  <= count_ff + CNT_W'(push_n) - CNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= step_out.rsp0;
      end
      if (push_n == 2'd2) begin
         fifo_ff[wr_ptr_ff + PTR_W'(1)] <= step_out.rsp1;
      end
   end

   // Head of the queue drives the result ports.
   assign head               = fifo_ff[rd_ptr_ff];
   assign rsp_page_address   = head.page_address;
   assign rsp_page_offset    = head.page_offset;
   assign rsp_segment_length = head.segment_length;
   assign rsp_segment_number = head.segment_number;
   assign rsp_status         = head.status;
   assign rsp_wants_list     = head.wants_list;
   assign rsp_last           = head.last;

`ifndef SYNTH
   // The queue never holds more than its depth.
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FIFO_DEPTH))
      else $error("result queue overflow");

   // The occupancy follows pushes and pops exactly.
   a_fifo_count: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff == $past(count_ff) + CNT_W'($past(push_n))
                                    - CNT_W'($past(pop)))
      else $error("result queue count out of step");

   // A held transaction stays in the input register until processed.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !fire) |=> in_valid_ff)
      else $error("input transaction lost");

   // A two-result step ends on its second result only.
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (fire && step_out.n_results == 2'd2) |-> step_out.rsp1.last && !step_out.rsp0.last)
      else $error("two-page results out of order");
`endif

endmodule

`default_nettype wire
